// ===== src/ipd_pkg.sv =====
// Package for the impact peak detector: reset values of the configuration
// registers, register index codes and small helper functions.
// No dependencies; the config channel, the front end, the back end, the top level and the test files use it.
package ipd_pkg;

    localparam int unsigned WINDOW_LEN_DEF = 50;

    localparam logic [15:0] THRESHOLD_RST = 16'd10000;
    localparam logic [15:0] HOLDOFF_RST   = 16'd2000;
    localparam logic [7:0]  PLAYER_RST    = 8'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned SAMPLE_W   = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HOLDOFF   = 2'd1,
        REG_PLAYER    = 2'd2
    } cfg_reg_t;

    // Signed maximum of two 16-bit samples.
    function automatic logic signed [15:0] smax16(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
        return (a > b) ? a : b;
    endfunction

    // Magnitude of a signed 16-bit sample; the most negative value gives 32768.
    function automatic logic [16:0] mag16(input logic [15:0] v);
        return v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
    endfunction

endpackage

// ===== src/ipd_sample_if.sv =====
// Handshake channel carrying one accelerometer sample beat.
// Depends on nothing.
interface ipd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        now_ms;

    modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

// ===== src/ipd_report_if.sv =====
// Handshake channel carrying one impact report beat.
// Depends on nothing.
interface ipd_report_if;
    logic               valid;
    logic               ready;
    logic [7:0]         report_player;
    logic signed [15:0] peak_x;
    logic signed [15:0] peak_y;
    logic signed [15:0] peak_z;

    modport source (output valid, report_player, peak_x, peak_y, peak_z, input ready);
    modport sink   (input valid, report_player, peak_x, peak_y, peak_z, output ready);
endinterface

// ===== src/ipd_cfg_if.sv =====
// Configuration write channel: register index and write data per beat.
// Depends on ipd_pkg for the field widths.
interface ipd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ipd_pkg::CFG_IDX_W-1:0]    index;
    logic [ipd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ipd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ipd_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 50,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ipd_front.sv =====
// Front end: configuration registers, sample intake, hit classification,
// arming and holdoff, and writes into the sample window RAM.
// Depends on ipd_pkg, ipd_sample_if and ipd_cfg_if.
module ipd_front #(
    parameter int unsigned WINDOW_LEN = ipd_pkg::WINDOW_LEN_DEF,
    localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1,
    localparam int unsigned FW = $clog2(WINDOW_LEN + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ipd_sample_if.sink                    sample,
    ipd_cfg_if.sink                       cfg,
    input  logic                          stall,
    output logic                          ram_we,
    output logic [AW-1:0]                 ram_waddr,
    output logic [ipd_pkg::SAMPLE_W-1:0]  ram_wdata,
    output logic                          rel_valid,
    output logic [7:0]                    rel_player,
    output logic [FW-1:0]                 rel_fill
);
    import ipd_pkg::*;

    logic [15:0]   threshold_reg;
    logic [15:0]   holdoff_reg;
    logic [7:0]    player_reg;
    logic [AW-1:0] slot_reg;
    logic [AW-1:0] slot_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic          armed_reg;
    logic [31:0]   last_hit_reg;

    logic          accept;
    logic          hit;
    logic          arm;
    logic [31:0]   elapsed;

    assign sample.ready = !stall;
    assign cfg.ready    = 1'b1;
    assign accept       = sample.valid && sample.ready;

    assign hit = (mag16(sample.accel_x) > {1'b0, threshold_reg}) ||
                 (mag16(sample.accel_y) > {1'b0, threshold_reg}) ||
                 (mag16(sample.accel_z) > {1'b0, threshold_reg});

    assign elapsed = sample.now_ms - last_hit_reg;
    assign arm     = hit && !armed_reg && (elapsed > {16'd0, holdoff_reg});

    assign slot_next = (slot_reg == AW'(WINDOW_LEN - 1)) ? '0 : slot_reg + AW'(1);
    assign fill_next = (fill_reg == FW'(WINDOW_LEN)) ? fill_reg : fill_reg + FW'(1);

    assign ram_we     = accept;
    assign ram_waddr  = slot_reg;
    assign ram_wdata  = {sample.accel_x, sample.accel_y, sample.accel_z};

    // A release carries the number of filled window entries, current sample included.
    assign rel_valid  = accept && !hit && armed_reg;
    assign rel_player = player_reg;
    assign rel_fill   = fill_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            holdoff_reg   <= HOLDOFF_RST;
            player_reg    <= PLAYER_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_THRESHOLD: threshold_reg <= cfg.data;
                REG_HOLDOFF:   holdoff_reg   <= cfg.data;
                REG_PLAYER:    player_reg    <= cfg.data[7:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            fill_reg     <= '0;
            armed_reg    <= 1'b0;
            last_hit_reg <= '0;
        end
        else if (accept)
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            if (arm)
            begin
                armed_reg    <= 1'b1;
                last_hit_reg <= sample.now_ms;
            end
            else if (!hit)
            begin
                armed_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/ipd_cmd_queue.sv =====
// Two-entry queue of release commands between the front and the back end.
// Depends on nothing.
module ipd_cmd_queue #(
    parameter int unsigned W = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] head
);

    logic [W-1:0] entry0_reg;
    logic [W-1:0] entry1_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign not_empty = (count_reg != 2'd0);
    assign head      = entry0_reg;
    assign do_push   = push && (count_reg != 2'd2);
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (do_push && !do_pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            if (do_push && (count_reg == 2'd1))
            begin
                entry0_reg <= push_data;
            end
            else
            begin
                entry0_reg <= entry1_reg;
            end
            if (do_push && (count_reg == 2'd2))
            begin
                entry1_reg <= push_data;
            end
        end
        else if (do_push)
        begin
            if (count_reg == 2'd0)
            begin
                entry0_reg <= push_data;
            end
            else
            begin
                entry1_reg <= push_data;
            end
        end
    end

endmodule

// ===== src/ipd_back.sv =====
// Back end: scans the filled part of the sample window one entry a cycle,
// keeps the running per-axis maximum and holds the report in an output register.
// Depends on ipd_pkg and ipd_report_if.
module ipd_back #(
    parameter int unsigned WINDOW_LEN = ipd_pkg::WINDOW_LEN_DEF,
    localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1,
    localparam int unsigned FW = $clog2(WINDOW_LEN + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic [FW+7:0]                 cmd_data,
    output logic                          cmd_pop,
    output logic [AW-1:0]                 ram_raddr,
    input  logic [ipd_pkg::SAMPLE_W-1:0]  ram_rdata,
    output logic                          busy,
    ipd_report_if.source                  report
);
    import ipd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic [AW-1:0]      last_addr_reg;
    logic               rd_pend_reg;
    logic               partial_reg;
    logic [7:0]         player_reg;
    logic signed [15:0] max_x_reg;
    logic signed [15:0] max_y_reg;
    logic signed [15:0] max_z_reg;
    logic               out_valid_reg;
    logic [7:0]         out_player_reg;
    logic signed [15:0] out_x_reg;
    logic signed [15:0] out_y_reg;
    logic signed [15:0] out_z_reg;

    logic [FW-1:0]      cmd_fill;
    logic [FW-1:0]      cmd_fill_m1;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] fin_x;
    logic signed [15:0] fin_y;
    logic signed [15:0] fin_z;

    assign cmd_fill    = cmd_data[FW-1:0];
    assign cmd_fill_m1 = cmd_fill - FW'(1);
    assign cmd_pop     = (state_reg == ST_IDLE) && cmd_valid && !out_valid_reg;
    assign busy        = (state_reg != ST_IDLE);
    assign ram_raddr   = rd_addr_reg;

    assign acc_x = smax16(max_x_reg, $signed(ram_rdata[47:32]));
    assign acc_y = smax16(max_y_reg, $signed(ram_rdata[31:16]));
    assign acc_z = smax16(max_z_reg, $signed(ram_rdata[15:0]));

    // Entries never written since reset are not scanned; a partly filled window counts them as zero.
    assign fin_x = partial_reg ? smax16(acc_x, 16'sd0) : acc_x;
    assign fin_y = partial_reg ? smax16(acc_y, 16'sd0) : acc_y;
    assign fin_z = partial_reg ? smax16(acc_z, 16'sd0) : acc_z;

    assign report.valid         = out_valid_reg;
    assign report.report_player = out_player_reg;
    assign report.peak_x        = out_x_reg;
    assign report.peak_y        = out_y_reg;
    assign report.peak_z        = out_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_addr_reg    <= '0;
            last_addr_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            partial_reg    <= 1'b0;
            player_reg     <= '0;
            max_x_reg      <= '0;
            max_y_reg      <= '0;
            max_z_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_player_reg <= '0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_z_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    rd_pend_reg <= 1'b0;
                    if (cmd_pop)
                    begin
                        rd_addr_reg   <= '0;
                        last_addr_reg <= cmd_fill_m1[AW-1:0];
                        partial_reg   <= (cmd_fill != FW'(WINDOW_LEN));
                        player_reg    <= cmd_data[FW+7:FW];
                        max_x_reg     <= 16'sh8000;
                        max_y_reg     <= 16'sh8000;
                        max_z_reg     <= 16'sh8000;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    rd_pend_reg <= 1'b1;
                    if (rd_pend_reg)
                    begin
                        max_x_reg <= acc_x;
                        max_y_reg <= acc_y;
                        max_z_reg <= acc_z;
                    end
                    if (rd_addr_reg == last_addr_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        rd_addr_reg <= rd_addr_reg + AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    rd_pend_reg    <= 1'b0;
                    out_valid_reg  <= 1'b1;
                    out_player_reg <= player_reg;
                    out_x_reg      <= fin_x;
                    out_y_reg      <= fin_y;
                    out_z_reg      <= fin_z;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/impact_peak_detector_top.sv =====
// Impact peak detector top level: front end, command queue, back end and window RAM.
// A beat that causes no report does not stop intake. After a releasing beat, intake
// waits until the back end has scanned the N filled entries (at most WINDOW_LEN) and
// registered the report, and longer while an earlier report still holds the output register.
// Reset restores the register defaults and marks the window empty with a fill count.
// Depends on ipd_pkg, the three channel interfaces and all ipd_* modules.
module impact_peak_detector_top #(
    parameter int unsigned WINDOW_LEN = ipd_pkg::WINDOW_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ipd_sample_if.sink    sample,
    ipd_cfg_if.sink       cfg,
    ipd_report_if.source  report
);
    import ipd_pkg::*;

    localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int unsigned FW = $clog2(WINDOW_LEN + 1);
    localparam int unsigned CW = FW + 8;

    // Window RAM write side, owned by the front end.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    // Window RAM read side, owned by the back end.
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Release commands travel through the queue as {player id, fill count}.
    logic                rel_valid;
    logic [7:0]          rel_player;
    logic [FW-1:0]       rel_fill;
    logic                cmd_valid;
    logic [CW-1:0]       cmd_data;
    logic                cmd_pop;
    logic                back_busy;

    // The window must not change while a release is waiting or being scanned,
    // so intake stops while the queue holds a command or the back end is scanning.
    // A finished report sitting in the output register does not stop intake.
    logic                front_stall;

    assign front_stall = cmd_valid || back_busy;

    ipd_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg),
        .stall      (front_stall),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .rel_valid  (rel_valid),
        .rel_player (rel_player),
        .rel_fill   (rel_fill)
    );

    ipd_cmd_queue #(
        .W (CW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rel_valid),
        .push_data ({rel_player, rel_fill}),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .head      (cmd_data)
    );

    ipd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The back end reads one window entry a cycle; its report waits in an output
    // register until the sink takes it, and a new scan starts only once it is free.
    ipd_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_pop   (cmd_pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .busy      (back_busy),
        .report    (report)
    );

endmodule

// ===== test/ipd_report_checker.sv =====
// Report checker for the impact peak detector: watches the sample, config and report
// channels, predicts every impact report and compares it with what the block emits.
// Depends on ipd_pkg and the three channel interfaces.
module ipd_report_checker #(
    parameter int unsigned WINDOW_LEN = ipd_pkg::WINDOW_LEN_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    ipd_sample_if sample,
    ipd_cfg_if    cfg,
    ipd_report_if report,
    output int    errors,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ipd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0]         player;
        logic signed [15:0] peak_x;
        logic signed [15:0] peak_y;
        logic signed [15:0] peak_z;
    } impact_report_t;

    // Shadow of the block: sample history, arming state and registers.
    logic signed [15:0] hist_x [WINDOW_LEN];
    logic signed [15:0] hist_y [WINDOW_LEN];
    logic signed [15:0] hist_z [WINDOW_LEN];
    int unsigned        slot;
    bit                 armed;
    logic [31:0]        last_arm_ms;
    logic [15:0]        threshold;
    logic [15:0]        holdoff_ms;
    logic [7:0]         player_id;

    impact_report_t     expected_reports [$];
    int                 fail_count;

    function automatic logic signed [15:0] window_peak(input logic signed [15:0] w [WINDOW_LEN]);
        logic signed [15:0] m;
        m = w[0];
        for (int i = 1; i < WINDOW_LEN; i++)
        begin
            if (w[i] > m)
            begin
                m = w[i];
            end
        end
        return m;
    endfunction

    // The most negative sample has magnitude 32768, so work in int.
    function automatic int magnitude(input logic signed [15:0] v);
        int s;
        s = v;
        return (s < 0) ? -s : s;
    endfunction

    task automatic absorb_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                 input logic signed [15:0] az, input logic [31:0] at_ms);
        bit             hit;
        impact_report_t rpt;
        hist_x[slot] = ax;
        hist_y[slot] = ay;
        hist_z[slot] = az;
        slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;

        hit = magnitude(ax) > int'(threshold) || magnitude(ay) > int'(threshold) ||
              magnitude(az) > int'(threshold);

        // Elapsed time is a wrapping 32-bit difference.
        if (hit && !armed && (at_ms - last_arm_ms) > {16'd0, holdoff_ms})
        begin
            armed       = 1'b1;
            last_arm_ms = at_ms;
        end

        if (!hit && armed)
        begin
            armed      = 1'b0;
            rpt.player = player_id;
            rpt.peak_x = window_peak(hist_x);
            rpt.peak_y = window_peak(hist_y);
            rpt.peak_z = window_peak(hist_z);
            expected_reports.push_back(rpt);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        impact_report_t got;
        impact_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                hist_x[i] = '0;
                hist_y[i] = '0;
                hist_z[i] = '0;
            end
            slot        = 0;
            armed       = 1'b0;
            last_arm_ms = '0;
            threshold   = THRESHOLD_RST;
            holdoff_ms  = HOLDOFF_RST;
            player_id   = PLAYER_RST;
            expected_reports.delete();
            fail_count  = 0;
            errors     <= 0;
            pending    <= 0;
        end
        else
        begin
            // Reports are retired before new samples are absorbed: a report never
            // belongs to a sample accepted at the same edge.
            if (report.valid && report.ready)
            begin
                got.player = report.report_player;
                got.peak_x = report.peak_x;
                got.peak_y = report.peak_y;
                got.peak_z = report.peak_z;
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("[%0t] unexpected report: player %0d peak (%0d, %0d, %0d)",
                                 $realtime, got.player, got.peak_x, got.peak_y, got.peak_z);
                    end
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display({"[%0t] report mismatch: expected player %0d peak ",
                                      "(%0d, %0d, %0d), got player %0d peak (%0d, %0d, %0d)"},
                                     $realtime, want.player, want.peak_x, want.peak_y,
                                     want.peak_z, got.player, got.peak_x, got.peak_y,
                                     got.peak_z);
                        end
                    end
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_THRESHOLD: threshold  = cfg.data;
                    REG_HOLDOFF:   holdoff_ms = cfg.data;
                    REG_PLAYER:    player_id  = cfg.data[7:0];
                    default:       ;
                endcase
            end

            if (sample.valid && sample.ready)
            begin
                absorb_sample(sample.accel_x, sample.accel_y, sample.accel_z, sample.now_ms);
            end

            errors  <= fail_count;
            pending <= expected_reports.size();
        end
    end

endmodule

// ===== test/tb_impact_peak_detector_top.sv =====
// Testbench top for the impact peak detector: clock, reset, sample and config stimulus,
// report back-pressure, watchdog and the final verdict.
// Depends on ipd_pkg, the channel interfaces, the block and ipd_report_checker.
module tb_impact_peak_detector_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ipd_pkg::*;

    localparam int unsigned           WINDOW_LEN    = WINDOW_LEN_DEF;
    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE     = 2'd3;
    // A release scans at most WINDOW_LEN entries.
    localparam int                    SETTLE_CYCLES = WINDOW_LEN + 8;
    localparam int                    LONG_HOLD     = 400;
    localparam int                    STALL_LIMIT   = 5000;
    localparam int                    PHASE_ITEMS   = 240;
    localparam int                    FLOOD_PAIRS   = 40;

    logic        clk;
    logic        rst_n;
    int          errors;
    int          pending;

    // Idling controls. The sender's rate is read only by the stimulus process; the
    // receiver's rate and the long hold-off request cross into the sink process and
    // are therefore changed with nonblocking assignments.
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          long_hold_reqs = 0;

    // Copies of the thresholds that shape the generated samples.
    logic [15:0] cur_threshold;
    logic [15:0] cur_holdoff;
    logic [31:0] stamp_ms;
    int          items_sent;

    ipd_sample_if sample_ch ();
    ipd_cfg_if    cfg_ch ();
    ipd_report_if report_ch ();

    impact_peak_detector_top #(
        .WINDOW_LEN (WINDOW_LEN)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .cfg    (cfg_ch),
        .report (report_ch)
    );

    ipd_report_checker #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_report_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .cfg     (cfg_ch),
        .report  (report_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Report sink. Normally ready follows the current stall rate. A long hold-off,
    // requested by the stimulus, keeps ready low until a countdown from LONG_HOLD, kept
    // here, runs out, while the sender keeps offering samples so that the block backs up.
    initial
    begin : report_sink
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        report_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_reqs != holds_served)
            begin
                holds_served = long_hold_reqs;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                report_ch.ready <= 1'b0;
            end
            else
            begin
                report_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: the run is hung when the quiet count, kept while no channel moves a beat, reaches STALL_LIMIT.
    // The slowest legal quiet stretch is the long hold-off plus a scan.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (report_ch.valid && report_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("** impact_peak_detector_top: FAILED **");
        $finish;
    end

    // Offers one sample beat, after a random gap, and returns at the edge that
    // accepts it. Valid stays high into the next call unless that call idles first.
    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [31:0] at_ms);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= ax;
        sample_ch.accel_y <= ay;
        sample_ch.accel_z <= az;
        sample_ch.now_ms  <= at_ms;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        items_sent++;
    endtask

    // Stops the sender and waits until every predicted report has come out, then
    // gives the block time to finish a scan that the checker did not predict.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One config beat; valid is left high so that beats can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
    endtask

    // Rewrites every register while the block is idle. The player word carries
    // upper bits that the block has to drop; the spare index gets random data.
    task automatic configure(input logic [15:0] thr, input logic [15:0] hold,
                             input logic [15:0] player_word);
        settle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_HOLDOFF, hold);
        write_reg(REG_PLAYER, player_word);
        write_reg(REG_SPARE, 16'($urandom()));
        cfg_ch.valid  <= 1'b0;
        cur_threshold = thr;
        cur_holdoff   = hold;
    endtask

    // An axis value that does not exceed the threshold.
    function automatic logic [15:0] quiet_value(input logic [15:0] thr);
        int lim;
        lim = (thr > 16'd32767) ? 32767 : int'(thr);
        return 16'(int'($urandom_range(2 * lim)) - lim);
    endfunction

    // An axis value whose magnitude exceeds the threshold, when one exists.
    function automatic logic [15:0] hit_value(input logic [15:0] thr);
        int mag;
        if (thr >= 16'd32768)
        begin
            return 16'($urandom());
        end
        mag = int'($urandom_range(32768, int'(thr) + 1));
        if (mag == 32768)
        begin
            return 16'h8000;
        end
        return ($urandom_range(1) != 0) ? 16'(-mag) : 16'(mag);
    endfunction

    // A well-formed impact: a few hit samples, then a few quiet ones. Most impacts
    // start after the holdoff has run out; some land inside it and must be ignored.
    task automatic send_event();
        int          n_hit;
        int          n_quiet;
        logic [2:0]  axes;
        logic [15:0] v [3];
        n_hit   = $urandom_range(1, 3);
        n_quiet = $urandom_range(1, 3);
        if ($urandom_range(9) < 7)
        begin
            stamp_ms += cur_holdoff + $urandom_range(1, 3000);
        end
        else
        begin
            stamp_ms += $urandom_range(int'(cur_holdoff));
        end
        repeat (n_hit)
        begin
            axes = 3'($urandom_range(1, 7));
            for (int a = 0; a < 3; a++)
            begin
                v[a] = axes[a] ? hit_value(cur_threshold) : quiet_value(cur_threshold);
            end
            send_sample(v[0], v[1], v[2], stamp_ms);
            stamp_ms += $urandom_range(1, 5);
        end
        repeat (n_quiet)
        begin
            send_sample(quiet_value(cur_threshold), quiet_value(cur_threshold),
                        quiet_value(cur_threshold), stamp_ms);
            stamp_ms += $urandom_range(1, 5);
        end
    endtask

    // Fully random sample; the timestamp sometimes jumps anywhere in its range.
    task automatic send_noise();
        if ($urandom_range(7) == 0)
        begin
            stamp_ms = $urandom();
        end
        else
        begin
            stamp_ms += $urandom_range(200);
        end
        send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()), stamp_ms);
    endtask

    task automatic random_phase(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(4) == 0)
            begin
                send_noise();
            end
            else
            begin
                send_event();
            end
        end
    endtask

    // Holds the report side off for a long stretch while every pair of samples
    // releases an impact, so that reports pile up and the sample input stalls.
    task automatic flood_while_held();
        long_hold_reqs <= long_hold_reqs + 1;
        repeat (FLOOD_PAIRS)
        begin
            stamp_ms += cur_holdoff + 1;
            send_sample(hit_value(cur_threshold), quiet_value(cur_threshold),
                        quiet_value(cur_threshold), stamp_ms);
            stamp_ms += 1;
            send_sample(quiet_value(cur_threshold), quiet_value(cur_threshold),
                        quiet_value(cur_threshold), stamp_ms);
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.accel_x <= '0;
        sample_ch.accel_y <= '0;
        sample_ch.accel_z <= '0;
        sample_ch.now_ms  <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_THRESHOLD;
        cfg_ch.data       <= '0;
        cur_threshold = THRESHOLD_RST;
        cur_holdoff   = HOLDOFF_RST;
        stamp_ms      = '0;
        items_sent    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults. A quiet sample first, then an impact whose window still
        // holds the zeros left by reset. The second hit arrives while armed and carries
        // both extremes of the sample range.
        send_sample(16'd0, 16'd0, 16'd0, 32'd100);
        send_sample(16'd10001, 16'd0, 16'd0, 32'd5000);
        send_sample(16'h8000, 16'h7FFF, -16'sd1, 32'd5001);
        send_sample(16'd5, -16'sd5, 16'd0, 32'd5002);
        // A hit inside the holdoff is dropped and the quiet sample after it says nothing.
        send_sample(16'd0, -16'sd20000, 16'd0, 32'd5100);
        send_sample(16'd0, 16'd0, 16'd0, 32'd5101);
        // Exactly the holdoff is not enough, exactly the threshold is not a hit,
        // one millisecond more arms.
        send_sample(16'd0, 16'd0, 16'd10001, 32'd7000);
        send_sample(16'd0, 16'd0, 16'd10000, 32'd7001);
        send_sample(16'd0, 16'd0, -16'sd10001, 32'd7001);
        send_sample(16'd0, 16'd0, 16'd0, 32'd7002);

        // Threshold just under full scale: only the most negative value is a hit.
        // The second impact straddles the wrap of the millisecond counter.
        configure(16'd32767, 16'd256, 16'hA55A);
        send_sample(16'h8000, 16'd0, 16'd0, 32'hFFFF_FF80);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FF81);
        send_sample(16'd0, 16'h8000, 16'd0, 32'h0000_0090);
        send_sample(16'd0, 16'd0, 16'd0, 32'h0000_0091);

        // Thresholds of full scale and above: nothing can ever arm.
        configure(16'd32768, 16'd0, 16'h00FF);
        send_sample(16'h8000, 16'h8000, 16'h8000, 32'h0000_1000);
        send_sample(16'd0, 16'd0, 16'd0, 32'h0000_1001);
        configure(16'hFFFF, 16'hFFFF, 16'hFF00);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 32'h0010_0000);

        // Zero threshold and zero holdoff: any nonzero value is a hit, and a hit
        // with the same timestamp as the last armed one does not re-arm.
        configure(16'd0, 16'd0, 16'h0001);
        send_sample(16'd0, 16'd0, 16'd1, 32'h0020_0000);
        send_sample(16'd0, 16'd0, 16'd0, 32'h0020_0000);
        send_sample(16'd1, 16'd0, 16'd0, 32'h0020_0000);
        send_sample(16'd0, 16'd0, 16'd0, 32'h0020_0000);
        send_sample(-16'sd1, 16'd0, 16'd0, 32'h0020_0001);
        send_sample(16'd0, 16'd0, 16'd0, 32'h0020_0002);

        stamp_ms = 32'h0020_0010;

        // Random part, no idling on either side, with one long report hold-off.
        configure(16'd12000, 16'd500, 16'($urandom()));
        random_phase(PHASE_ITEMS / 2);
        flood_while_held();
        random_phase(PHASE_ITEMS / 2);

        // Sender mostly idle.
        configure(16'($urandom_range(32768)), 16'($urandom_range(3000)), 16'($urandom()));
        send_idle_pct = 85;
        random_phase(PHASE_ITEMS);

        // Receiver mostly stalling; smallest nonzero threshold, longest holdoff.
        configure(16'd1, 16'hFFFF, 16'($urandom()));
        send_idle_pct = 0;
        recv_stall_pct <= 85;
        random_phase(PHASE_ITEMS);

        // Light idling on both sides.
        configure(16'd32767, 16'd0, 16'($urandom()));
        send_idle_pct = 7;
        recv_stall_pct <= 7;
        random_phase(PHASE_ITEMS);

        settle();
        if (errors == 0)
        begin
            $display("** impact_peak_detector_top: PASSED **");
        end
        else
        begin
            $display("** impact_peak_detector_top: FAILED **");
        end
        $finish;
    end

endmodule
